### hw/rtl/lwbc_pkg.sv
// Shared types and constants of the LRU write-back block cache tag engine.
// Used by the cell row, the top level and the port checker; depends on nothing.

package lwbc_pkg;

   localparam int TAG_W       = 32;
   localparam int REQ_W       = 40;
   localparam int RSP_W       = 72;
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 5;
   localparam int MAX_RESULTS = 16;
   localparam int FLUSH_CNT_W = $clog2(MAX_RESULTS);

   typedef enum logic [1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_FLUSH = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_BLOCK_SHIFT = 1'd0,
      CSR_CAPACITY    = 1'd1
   } csr_addr_type;

   // What the row of cells does in one cycle.
   typedef enum logic [2:0] {
      CMD_IDLE  = 3'd0,
      CMD_HIT   = 3'd1,
      CMD_FILL  = 3'd2,
      CMD_EVICT = 3'd3,
      CMD_FLUSH = 3'd4
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic             write;
      logic [TAG_W-1:0] tag;
   } cell_cmd_type;

   typedef struct packed {
      logic             match;
      logic             victim;
      logic             flush_cand;
      logic             flush_grant;
      logic             dirty;
      logic [TAG_W-1:0] tag;
   } cell_stat_type;

endpackage

### hw/rtl/lwbc_cell.sv
// One slot of the cache: block tag, valid, dirty and recency rank.
// Depends on lwbc_pkg; chained to its neighbors through the free and flush ripple.

module lwbc_cell #(
   parameter int RANK_W = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lwbc_pkg::cell_cmd_type cmd,
   input  logic [RANK_W-1:0]      old_rank,
   input  logic [RANK_W-1:0]      victim_rank,
   input  logic                   free_in,
   output logic                   free_out,
   input  logic                   flush_in,
   output logic                   flush_out,
   output lwbc_pkg::cell_stat_type stat,
   output logic [RANK_W-1:0]      rank_out
);

   logic [lwbc_pkg::TAG_W-1:0] tag_ff, tag_in;
   logic                       valid_ff, valid_in;
   logic                       dirty_ff, dirty_in;
   logic [RANK_W-1:0]          rank_ff, rank_in;

   logic match, free_grant, victim, cand, flush_grant, older;

   assign match       = valid_ff && (tag_ff == cmd.tag);
   // A lower cell that is free or dirty takes the grant first.
   assign free_grant  = !valid_ff && !free_in;
   assign free_out    = free_in || !valid_ff;
   assign cand        = valid_ff && dirty_ff;
   assign flush_grant = cand && !flush_in;
   assign flush_out   = flush_in || cand;
   assign victim      = valid_ff && (rank_ff == victim_rank);
   assign older       = valid_ff && (rank_ff < old_rank);

   always_comb begin
      tag_in   = tag_ff;
      valid_in = valid_ff;
      dirty_in = dirty_ff;
      rank_in  = rank_ff;
      case (cmd.kind)
         lwbc_pkg::CMD_HIT: begin
            if (match) begin
               rank_in = '0;
               if (cmd.write) begin
                  dirty_in = 1'b1;
               end
            end else if (older) begin
               rank_in = rank_ff + RANK_W'(1);
            end
         end
         lwbc_pkg::CMD_FILL: begin
            if (free_grant) begin
               tag_in   = cmd.tag;
               valid_in = 1'b1;
               dirty_in = cmd.write;
               rank_in  = '0;
            end else if (valid_ff) begin
               rank_in = rank_ff + RANK_W'(1);
            end
         end
         lwbc_pkg::CMD_EVICT: begin
            if (victim) begin
               tag_in   = cmd.tag;
               valid_in = 1'b1;
               dirty_in = cmd.write;
               rank_in  = '0;
            end else if (older) begin
               rank_in = rank_ff + RANK_W'(1);
            end
         end
         lwbc_pkg::CMD_FLUSH: begin
            if (flush_grant) begin
               dirty_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
      if (reset) begin
         valid_ff <= 1'b0;
         dirty_ff <= 1'b0;
         rank_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         dirty_ff <= dirty_in;
         rank_ff  <= rank_in;
      end
   end

   assign stat.match       = match;
   assign stat.victim      = victim;
   assign stat.flush_cand  = cand;
   assign stat.flush_grant = flush_grant;
   assign stat.dirty       = dirty_ff;
   assign stat.tag         = tag_ff;
   assign rank_out         = rank_ff;

endmodule

### hw/rtl/lru_writeback_block_cache.sv
// Top level of the LRU write-back block cache tag engine: request capture, control
// and result register around a row of lwbc_cell slots. Depends on lwbc_pkg, lwbc_cell.

// A read or write access is accepted in ST_IDLE, where the block start is formed, then
// handled in ST_ACCESS once the output is free: every slot compares its tag, the first
// free slot is found by a ripple through the cell row and all slots update their
// recency ranks; the next item is accepted in the cycle after that. A flush gives one
// result per cycle while the output is free, at most 16 per flush, each granting the
// first dirty slot through the same kind of ripple; a flush with no dirty block gives
// one empty result. Results sit in an output register, so a new item is taken while
// the last result waits. The tag store needs no clearing pass after reset.

module lru_writeback_block_cache #(
   parameter int ENTRIES     = 16,
   parameter int OFFSET_BITS = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // action [1:0], byte_offset [33:2], zeros above
   input  logic [lwbc_pkg::REQ_W-1:0]      req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // hit [0], fill_needed [1], block_base [33:2], victim_valid [34],
   // victim_dirty [35], victim_block [67:36], zeros above
   output logic [lwbc_pkg::RSP_W-1:0]      rsp_tdata,
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [lwbc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [lwbc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int TAG_W    = lwbc_pkg::TAG_W;
   localparam int RANK_W   = $clog2(ENTRIES);
   localparam int CNT_W    = $clog2(ENTRIES + 1);
   localparam int CAP_W    = lwbc_pkg::CSR_DATA_W;
   localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int KEEP_W   = (OFFSET_BITS < TAG_W) ? OFFSET_BITS : TAG_W;
   localparam logic [TAG_W-1:0] OFF_MASK = {TAG_W{1'b1}} >> (TAG_W - KEEP_W);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_FLUSH
   } state_type;

   state_type                        state_ff, state_in;
   lwbc_pkg::action_type             action_ff, action_in;
   logic [TAG_W-1:0]                 start_ff, start_in;
   logic [lwbc_pkg::FLUSH_CNT_W-1:0] flush_cnt_ff, flush_cnt_in;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic [CAP_W-1:0]                 block_shift_ff, capacity_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             hit_ff, hit_in;
   logic             fill_ff, fill_in;
   logic [TAG_W-1:0] bstart_ff, bstart_in;
   logic             vvalid_ff, vvalid_in;
   logic             vdirty_ff, vdirty_in;
   logic [TAG_W-1:0] vblock_ff, vblock_in;
   logic             last_ff, last_in;

   lwbc_pkg::cell_cmd_type  cmd;
   lwbc_pkg::cell_stat_type stat [ENTRIES];
   logic [RANK_W-1:0]       rank [ENTRIES];
   logic [ENTRIES:0]        free_chain, flush_chain;
   logic [RANK_W-1:0]       old_rank, victim_rank;

   logic                    any_match, other_dirty, victim_dirty, need_evict, out_free;
   logic [RANK_W-1:0]       hit_rank;
   logic [TAG_W-1:0]        victim_tag, flush_tag, req_offset;
   logic [CAP_W-1:0]        cap_eff;

   assign free_chain[0]  = 1'b0;
   assign flush_chain[0] = 1'b0;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      lwbc_cell #(.RANK_W(RANK_W)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .old_rank    (old_rank),
         .victim_rank (victim_rank),
         .free_in     (free_chain[g]),
         .free_out    (free_chain[g+1]),
         .flush_in    (flush_chain[g]),
         .flush_out   (flush_chain[g+1]),
         .stat        (stat[g]),
         .rank_out    (rank[g])
      );
   end

   // Valid ranks always form 0 .. count-1, so the oldest block holds rank count-1.
   assign victim_rank = RANK_W'(count_ff - CNT_W'(1));

   always_comb begin
      any_match    = 1'b0;
      other_dirty  = 1'b0;
      victim_dirty = 1'b0;
      hit_rank     = '0;
      victim_tag   = '0;
      flush_tag    = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         any_match    = any_match | stat[i].match;
         other_dirty  = other_dirty | (stat[i].flush_cand & ~stat[i].flush_grant);
         victim_dirty = victim_dirty | (stat[i].victim & stat[i].dirty);
         hit_rank     = hit_rank | (rank[i] & {RANK_W{stat[i].match}});
         victim_tag   = victim_tag | (stat[i].tag & {TAG_W{stat[i].victim}});
         flush_tag    = flush_tag | (stat[i].tag & {TAG_W{stat[i].flush_grant}});
      end
   end

   assign cap_eff    = (capacity_ff == '0) ? CAP_W'(1) : capacity_ff;
   assign need_evict = !free_chain[ENTRIES] ||
                       (CMP_W'(count_ff) >= CMP_W'(cap_eff));
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_offset = req_tdata[TAG_W+1:2];

   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      start_in     = start_ff;
      flush_cnt_in = flush_cnt_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      hit_in       = hit_ff;
      fill_in      = fill_ff;
      bstart_in    = bstart_ff;
      vvalid_in    = vvalid_ff;
      vdirty_in    = vdirty_ff;
      vblock_in    = vblock_ff;
      last_in      = last_ff;
      cmd.kind     = lwbc_pkg::CMD_IDLE;
      cmd.write    = (action_ff == lwbc_pkg::ACT_WRITE);
      cmd.tag      = start_ff;
      old_rank     = hit_rank;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               action_in    = lwbc_pkg::action_type'(req_tdata[1:0]);
               start_in     = req_offset & OFF_MASK & ({TAG_W{1'b1}} << block_shift_ff);
               flush_cnt_in = '0;
               state_in     = (req_tdata[1:0] == lwbc_pkg::ACT_FLUSH) ? ST_FLUSH : ST_ACCESS;
            end
         end
         ST_ACCESS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               hit_in       = 1'b0;
               fill_in      = 1'b0;
               bstart_in    = '0;
               vvalid_in    = 1'b0;
               vdirty_in    = 1'b0;
               vblock_in    = '0;
               last_in      = 1'b1;
               state_in     = ST_IDLE;
               unique case (action_ff) inside
                  lwbc_pkg::ACT_READ, lwbc_pkg::ACT_WRITE: begin
                     bstart_in = start_ff;
                     if (any_match) begin
                        cmd.kind = lwbc_pkg::CMD_HIT;
                        hit_in   = 1'b1;
                     end else if (need_evict) begin
                        cmd.kind  = lwbc_pkg::CMD_EVICT;
                        old_rank  = victim_rank;
                        fill_in   = 1'b1;
                        vvalid_in = 1'b1;
                        vdirty_in = victim_dirty;
                        vblock_in = victim_tag;
                     end else begin
                        cmd.kind = lwbc_pkg::CMD_FILL;
                        fill_in  = 1'b1;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               hit_in       = 1'b0;
               fill_in      = 1'b0;
               bstart_in    = '0;
               if (flush_chain[ENTRIES]) begin
                  cmd.kind  = lwbc_pkg::CMD_FLUSH;
                  vvalid_in = 1'b1;
                  vdirty_in = 1'b1;
                  vblock_in = flush_tag;
                  last_in   = !other_dirty ||
                              (flush_cnt_ff == lwbc_pkg::FLUSH_CNT_W'(lwbc_pkg::MAX_RESULTS - 1));
                  flush_cnt_in = flush_cnt_ff + lwbc_pkg::FLUSH_CNT_W'(1);
               end else begin
                  vvalid_in = 1'b0;
                  vdirty_in = 1'b0;
                  vblock_in = '0;
                  last_in   = 1'b1;
               end
               if (last_in) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      action_ff    <= action_in;
      start_ff     <= start_in;
      flush_cnt_ff <= flush_cnt_in;
      hit_ff       <= hit_in;
      fill_ff      <= fill_in;
      bstart_ff    <= bstart_in;
      vvalid_ff    <= vvalid_in;
      vdirty_ff    <= vdirty_in;
      vblock_ff    <= vblock_in;
      last_ff      <= last_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         block_shift_ff <= CAP_W'(12);
         capacity_ff    <= CAP_W'(16);
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_addr)
               lwbc_pkg::CSR_BLOCK_SHIFT: block_shift_ff <= csr_wdata;
               lwbc_pkg::CSR_CAPACITY:    capacity_ff    <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {4'b0000, vblock_ff, vdirty_ff, vvalid_ff, bstart_ff, fill_ff, hit_ff};

endmodule

### hw/rtl/lwbc_checker.sv
// Port-level checks of the LRU write-back block cache and the bind that attaches them.
// Depends on lwbc_pkg and on the port list of lru_writeback_block_cache.

module lwbc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [lwbc_pkg::RSP_W-1:0]      rsp_tdata,
   input logic                            rsp_tlast
);

   // A held result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // No item is taken in the cycle after another item is taken.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted in back-to-back cycles");

   a_hit_no_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("hit result asks for a fill");

   a_dirty_needs_victim: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[35] |-> rsp_tdata[34])
      else $error("dirty mark without a victim");

   // A victim without a fill comes only from a flush, which writes back dirty blocks.
   a_flush_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[34] && !rsp_tdata[1] |-> rsp_tdata[35] && !rsp_tdata[0])
      else $error("malformed flush result");

endmodule

bind lru_writeback_block_cache lwbc_checker u_lwbc_checker (.*);
